// ===== sv/tpc_pkg.sv =====
// tpc_pkg: shared types, codes and helpers of the trie prefix counter
// no dependencies, compile first
`default_nettype none

package tpc_pkg;

    localparam int LETTER_W    = 5;
    localparam int COUNT_W     = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // front queue, power of two so the pointers wrap
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // classified item as held in the queue
    typedef struct packed {
        logic                kind;
        logic [LETTER_W-1:0] letter;
        logic                has_letter;
        logic                bad_query;
        logic                last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tpc_ram.sv =====
// tpc_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module tpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/tpc_front.sv =====
// tpc_front: command intake, letter classification and the item queue
// depends on tpc_pkg
`default_nettype none

module tpc_front #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [tpc_pkg::LETTER_W-1:0]  i_letter,
    input  wire logic                          i_no_letter,
    input  wire logic                          i_last,
    output tpc_pkg::t_q_head                   o_head,
    input  wire tpc_pkg::t_back_ctl            i_ctl
);
    import tpc_pkg::*;

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               push, pop, in_range;
    t_item              item;

    assign busy     = (r_cnt == QCNT_W'(QUEUE_DEPTH)) || i_ctl.clearing;
    assign push     = start && !busy;
    assign pop      = i_ctl.pop;
    assign in_range = 32'(i_letter) < ALPHABET_SIZE;

    always_comb begin
        item.kind       = i_kind;
        item.letter     = in_range ? i_letter : '0;
        item.has_letter = !i_no_letter && in_range;
        item.bad_query  = (i_kind == KIND_QUERY) && !i_no_letter && !in_range;
        item.last       = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rd];

endmodule

`default_nettype wire

// ===== sv/tpc_back.sv =====
// tpc_back: trie walker, node pool, child table and count memories
// depends on tpc_pkg and tpc_ram
`default_nettype none

module tpc_back #(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tpc_pkg::t_q_head             i_head,
    output tpc_pkg::t_back_ctl                o_ctl,
    output logic                              o_valid,
    output logic                              o_was_query,
    output logic                              o_found,
    output logic [tpc_pkg::COUNT_W-1:0]       o_term_count,
    output logic [tpc_pkg::COUNT_W-1:0]       o_prefix_count,
    output logic                              o_pool_overflow
);
    import tpc_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int UW    = $clog2(MAX_NODES + 1);
    localparam int SLOTS = MAX_NODES * ALPHABET_SIZE;
    localparam int SW    = $clog2(SLOTS);
    localparam logic [SW-1:0] CLR_LAST  = SW'(SLOTS - 1);
    localparam logic [UW-1:0] POOL_FULL = UW'(MAX_NODES);

    typedef enum logic [4:0] {
        S_CLEAR   = 5'b00001,
        S_IDLE    = 5'b00010,
        S_EXEC    = 5'b00100,
        S_FIN_RD  = 5'b01000,
        S_FIN_OUT = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_clr, n_clr;
    logic [NW-1:0]     r_node, n_node;
    logic [UW-1:0]     r_used, n_used;
    logic              r_miss, n_miss, r_ovf, n_ovf;
    t_item             r_item, n_item;
    logic [SW-1:0]     r_slot, n_slot, slot_c;

    logic              r_out_valid, n_out_valid;
    logic              r_was_query, n_was_query, r_found, n_found, r_povf, n_povf;
    logic [COUNT_W-1:0] r_end, n_end, r_pre, n_pre;

    logic              child_we, pass_we, end_we, pop, child_hit, clr_in_pool;
    logic [SW-1:0]     child_waddr;
    logic [NW-1:0]     child_wdata, child_rdata;
    logic [NW-1:0]     pass_waddr, end_waddr;
    logic [COUNT_W-1:0] pass_wdata, pass_rdata, end_wdata, end_rdata;

    tpc_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_child (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_raddr (slot_c),
        .o_rdata (child_rdata)
    );

    tpc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_pass (
        .i_clk   (i_clk),
        .i_we    (pass_we),
        .i_waddr (pass_waddr),
        .i_wdata (pass_wdata),
        .i_raddr (r_node),
        .o_rdata (pass_rdata)
    );

    tpc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_end (
        .i_clk   (i_clk),
        .i_we    (end_we),
        .i_waddr (end_waddr),
        .i_wdata (end_wdata),
        .i_raddr (r_node),
        .o_rdata (end_rdata)
    );

    assign slot_c      = SW'(32'(r_node) * ALPHABET_SIZE + 32'(i_head.item.letter));
    assign child_hit   = (child_rdata != '0);
    assign clr_in_pool = 32'(r_clr) < MAX_NODES;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_used      = r_used;
        n_miss      = r_miss;
        n_ovf       = r_ovf;
        n_item      = r_item;
        n_slot      = r_slot;
        n_out_valid = 1'b0;
        n_was_query = r_was_query;
        n_found     = r_found;
        n_end       = r_end;
        n_pre       = r_pre;
        n_povf      = r_povf;
        pop         = 1'b0;
        child_we    = 1'b0;
        child_waddr = r_slot;
        child_wdata = r_used[NW-1:0];
        pass_we     = 1'b0;
        pass_waddr  = r_node;
        pass_wdata  = sat_inc(pass_rdata);
        end_we      = 1'b0;
        end_waddr   = r_node;
        end_wdata   = sat_inc(end_rdata);

        unique case (r_state)
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_clr;
                child_wdata = '0;
                pass_we     = clr_in_pool;
                pass_waddr  = r_clr[NW-1:0];
                pass_wdata  = '0;
                end_we      = clr_in_pool;
                end_waddr   = r_clr[NW-1:0];
                end_wdata   = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // child and pass reads go out at the head's slot and the current node
                if (i_head.valid) begin
                    pop     = 1'b1;
                    n_item  = i_head.item;
                    n_slot  = slot_c;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.has_letter && r_item.kind == KIND_INSERT && !r_ovf) begin
                    if (child_hit) begin
                        pass_we = 1'b1;
                        n_node  = child_rdata;
                    end else if (r_used == POOL_FULL) begin
                        n_ovf = 1'b1;
                    end else begin
                        child_we = 1'b1;
                        pass_we  = 1'b1;
                        n_node   = r_used[NW-1:0];
                        n_used   = r_used + 1'b1;
                    end
                end else if (r_item.kind == KIND_QUERY && !r_miss
                             && (r_item.has_letter || r_item.bad_query)) begin
                    if (r_item.bad_query || !child_hit) begin
                        n_miss = 1'b1;
                    end else begin
                        n_node = child_rdata;
                    end
                end
                n_state = r_item.last ? S_FIN_RD : S_IDLE;
            end
            S_FIN_RD: begin
                n_state = S_FIN_OUT;
            end
            S_FIN_OUT: begin
                n_out_valid = 1'b1;
                n_was_query = (r_item.kind == KIND_QUERY);
                n_found     = (r_item.kind == KIND_QUERY) && !r_miss;
                n_end       = n_found ? end_rdata : '0;
                n_pre       = n_found ? pass_rdata : '0;
                n_povf      = (r_item.kind == KIND_INSERT) && r_ovf;
                end_we      = (r_item.kind == KIND_INSERT) && !r_ovf;
                n_node      = '0;
                n_miss      = 1'b0;
                n_ovf       = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_node      <= '0;
            r_used      <= UW'(1);
            r_miss      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_node      <= n_node;
            r_used      <= n_used;
            r_miss      <= n_miss;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_slot      <= n_slot;
        r_was_query <= n_was_query;
        r_found     <= n_found;
        r_end       <= n_end;
        r_pre       <= n_pre;
        r_povf      <= n_povf;
    end

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = (r_state == S_CLEAR);

    assign o_valid         = r_out_valid;
    assign o_was_query     = r_was_query;
    assign o_found         = r_found;
    assign o_term_count    = r_end;
    assign o_prefix_count  = r_pre;
    assign o_pool_overflow = r_povf;

endmodule

`default_nettype wire

// ===== sv/trie_prefix_counter_unit.sv =====
// a final item accepted into an empty unit passes the queue, S_IDLE, S_EXEC, S_FIN_RD and
// S_FIN_OUT before its registered result strobe; the last two do the end/prefix count read
// and end-count write; a letter holds the back end in S_IDLE and S_EXEC, as the registered
// child-table read must return before the next letter's lookup; a 2-entry queue decouples
// intake; reset: synchronous, active low; a clearing pass over all MAX_NODES*ALPHABET_SIZE
// slots (26624 by default) follows, busy stays high throughout; results cannot be stalled
`default_nettype none

module trie_prefix_counter_unit #(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // command side: a transaction is taken when start is high and busy low
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [tpc_pkg::LETTER_W-1:0]  i_letter,
    input  wire logic                          i_no_letter,
    input  wire logic                          i_last,
    // result side: one-cycle strobe per finished word
    output logic                               o_valid,
    output logic                               o_was_query,
    output logic                               o_found,
    output logic [tpc_pkg::COUNT_W-1:0]        o_term_count,
    output logic [tpc_pkg::COUNT_W-1:0]        o_prefix_count,
    output logic                               o_pool_overflow
);
    import tpc_pkg::*;

    // queue head towards the walker, pop and clearing status back
    t_q_head   head;
    t_back_ctl ctl;

    // front: classifies each letter (valid, out of range, absent) and queues it
    tpc_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_letter    (i_letter),
        .i_no_letter (i_no_letter),
        .i_last      (i_last),
        .o_head      (head),
        .i_ctl       (ctl)
    );

    // back: walks the trie, allocates nodes, keeps saturating counts
    tpc_back #(.MAX_NODES(MAX_NODES), .ALPHABET_SIZE(ALPHABET_SIZE)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_ctl           (ctl),
        .o_valid         (o_valid),
        .o_was_query     (o_was_query),
        .o_found         (o_found),
        .o_term_count    (o_term_count),
        .o_prefix_count  (o_prefix_count),
        .o_pool_overflow (o_pool_overflow)
    );

endmodule

`default_nettype wire

// ===== sv/tpc_checker.sv =====
// tpc_checker: port-level checks on the trie prefix counter results
// depends on tpc_pkg, bound to trie_prefix_counter_unit
`default_nettype none

module tpc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         busy,
    input wire logic                         o_valid,
    input wire logic                         o_was_query,
    input wire logic                         o_found,
    input wire logic [tpc_pkg::COUNT_W-1:0]  o_term_count,
    input wire logic [tpc_pkg::COUNT_W-1:0]  o_prefix_count,
    input wire logic                         o_pool_overflow
);
    import tpc_pkg::*;

    // a reset always starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    // each word passes S_IDLE, S_EXEC, S_FIN_RD and S_FIN_OUT in the back end, so strobes never touch
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes back to back");

    a_query_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_query) |-> !o_pool_overflow)
        else $error("overflow reported on a query");

    a_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_was_query) |->
        (!o_found && o_term_count == '0 && o_prefix_count == '0))
        else $error("insert result carries counts");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_term_count == '0 && o_prefix_count == '0))
        else $error("miss result carries counts");

endmodule

bind trie_prefix_counter_unit tpc_checker u_tpc_checker (.*);

`default_nettype wire
